[hdl/glcm_pkg.sv]
package glcm_pkg;

    // Input item kinds, as carried on the slave-side tuser bit.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRAY_LEVELS    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIRECTION_MODE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_DISTANCE  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT   = 3'd4;

    localparam logic [3:0] MODE_ALL = 4'd12;

    localparam int COUNT_BITS = 20;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 20'hFFFFF;

    // Last of the eight offset directions.
    localparam logic [2:0] DIR_LAST = 3'd7;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPW         = 2;

    typedef enum logic {
        CMD_LOAD,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] pixel;
        logic        last;
        logic [7:0]  ref_level;
        logic [7:0]  neighbor_level;
    } cmd_t;

    typedef struct packed {
        logic clearing;
        logic rd_wait;
    } back_status_t;

    // Offsets selected by each direction mode, bit k for direction k.
    function automatic logic [7:0] mode_mask(input logic [3:0] mode);
        logic [7:0] m;
        unique case (mode)
            4'd0:    m = 8'h01;
            4'd1:    m = 8'h02;
            4'd2:    m = 8'h04;
            4'd3:    m = 8'h08;
            4'd4:    m = 8'h10;
            4'd5:    m = 8'h20;
            4'd6:    m = 8'h40;
            4'd7:    m = 8'h80;
            4'd8:    m = 8'h03;
            4'd9:    m = 8'h06;
            4'd10:   m = 8'h0C;
            4'd11:   m = 8'h09;
            4'd12:   m = 8'hFF;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    // Row direction of offset k: +1, 0 or -1.
    function automatic logic signed [1:0] dir_row(input logic [2:0] k);
        logic signed [1:0] r;
        unique case (k)
            3'd1, 3'd4, 3'd5: r = 2'sd1;
            3'd3, 3'd6, 3'd7: r = -2'sd1;
            default:          r = 2'sd0;
        endcase
        return r;
    endfunction

    // Column direction of offset k: +1, 0 or -1.
    function automatic logic signed [1:0] dir_col(input logic [2:0] k);
        logic signed [1:0] c;
        unique case (k)
            3'd0, 3'd4, 3'd7: c = 2'sd1;
            3'd2, 3'd5, 3'd6: c = -2'sd1;
            default:          c = 2'sd0;
        endcase
        return c;
    endfunction

endpackage

[hdl/glcm_ram.sv]
module glcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/glcm_front.sv]
module glcm_front
    import glcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    input  logic        s_tuser,
    input  logic        pop,
    output logic        cmd_valid,
    output cmd_t        cmd
);

    cmd_t           q_mem_reg [QUEUE_DEPTH];
    logic [QPW-1:0] wr_ptr_reg;
    logic [QPW-1:0] rd_ptr_reg;
    logic [QPW:0]   count_reg;
    logic           push;
    cmd_t           cmd_in;

    // Classify the item and keep only what the back end needs.
    always_comb
    begin
        cmd_in.kind           = (s_tuser == OP_READ) ? CMD_READ : CMD_LOAD;
        cmd_in.pixel          = s_tdata[15:0];
        cmd_in.last           = s_tlast;
        cmd_in.ref_level      = s_tdata[23:16];
        cmd_in.neighbor_level = s_tdata[31:24];
    end

    assign s_tready  = (count_reg != (QPW+1)'(QUEUE_DEPTH));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hdl/glcm_quant.sv]
module glcm_quant #(
    parameter int PB = 16,
    parameter int QB = 9
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [PB-1:0] pix,
    input  logic [PB-1:0] maxv,
    input  logic [QB-1:0] levels,
    output logic          done,
    output logic [QB-1:0] level
);

    // Quotient of (2*v*L + max) / (2*max), one bit per cycle.
    localparam int PW = PB + QB;
    localparam int NW = PB + QB + 2;
    localparam int KB = $clog2(QB);

    typedef enum logic [1:0] {
        Q_IDLE,
        Q_MUL,
        Q_DIV
    } q_state_t;

    q_state_t      state_reg, state_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [PB-1:0] max_reg, max_next;
    logic [QB-1:0] lv_reg, lv_next;
    logic [NW-1:0] rem_reg, rem_next;
    logic [NW-1:0] dsh_reg, dsh_next;
    logic [QB-1:0] q_reg, q_next;
    logic [KB-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [QB-1:0] level_reg, level_next;
    logic          ge;

    always_comb
    begin
        state_next = state_reg;
        prod_next  = prod_reg;
        max_next   = max_reg;
        lv_next    = lv_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        level_next = level_reg;
        done_next  = 1'b0;
        ge         = (rem_reg >= dsh_reg);
        unique case (state_reg)
            Q_IDLE:
            begin
                if (start)
                begin
                    prod_next  = PW'(pix) * PW'(levels);
                    max_next   = maxv;
                    lv_next    = levels;
                    state_next = Q_MUL;
                end
            end
            Q_MUL:
            begin
                rem_next   = NW'({prod_reg, 1'b0}) + NW'(max_reg);
                dsh_next   = NW'({max_reg, 1'b0}) << (QB - 1);
                q_next     = '0;
                cnt_next   = KB'(QB - 1);
                state_next = Q_DIV;
            end
            Q_DIV:
            begin
                if (ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                q_next   = {q_reg[QB-2:0], ge};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = Q_IDLE;
                    if (max_reg == '0)
                    begin
                        level_next = '0;
                    end
                    else if (q_next >= lv_reg)
                    begin
                        level_next = lv_reg - 1'b1;
                    end
                    else
                    begin
                        level_next = q_next;
                    end
                end
            end
            default:
            begin
                state_next = Q_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= Q_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        max_reg   <= max_next;
        lv_reg    <= lv_next;
        rem_reg   <= rem_next;
        dsh_reg   <= dsh_next;
        q_reg     <= q_next;
        cnt_reg   <= cnt_next;
        level_reg <= level_next;
    end

    assign done  = done_reg;
    assign level = level_reg;

endmodule

[hdl/glcm_back.sv]
module glcm_back
    import glcm_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_LEVELS = 256,
    parameter int PIXEL_BITS = 16,
    localparam int QB = $clog2(MAX_LEVELS + 1),
    localparam int XB = $clog2(MAX_WIDTH + 1),
    localparam int YB = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [QB-1:0]         lv,
    input  logic [3:0]            mode,
    input  logic [7:0]            step,
    input  logic [XB-1:0]         w,
    input  logic [YB-1:0]         h,
    input  logic                  cmd_valid,
    input  cmd_t                  cmd,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COUNT_BITS-1:0] m_count,
    output logic                  m_err,
    output back_status_t          status
);

    localparam int PB     = (PIXEL_BITS < 16) ? PIXEL_BITS : 16;
    localparam int IDEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int IA     = $clog2(IDEPTH);
    localparam int PIB    = $clog2(IDEPTH + 1);
    localparam int LB     = $clog2(MAX_LEVELS);
    localparam int CA     = 2 * LB;
    localparam int CDEPTH = 1 << CA;
    localparam int MD     = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int CB0    = $clog2(MD + 1);
    localparam int CB     = ((CB0 > 9) ? CB0 : 9) + 2;
    localparam int DW     = IA + 3;
    localparam int NWB    = 8 + XB;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_WAIT,
        S_Q_READ,
        S_Q_START,
        S_Q_WAIT,
        S_OFS_SEL,
        S_OFS_MUL,
        S_OFS_ADD,
        S_PAIR,
        S_P_LVL,
        S_P_INC
    } state_t;

    state_t                  state_reg, state_next;
    logic                    compute_reg, compute_next;
    logic [CA-1:0]           clr_reg, clr_next;
    logic [PIB-1:0]          pix_idx_reg, pix_idx_next;
    logic [PB-1:0]           max_reg, max_next;
    logic                    err_reg, err_next;
    logic [IA-1:0]           idx_reg, idx_next;
    logic [2:0]              k_reg, k_next;
    logic [IA:0]             nw_reg, nw_next;
    logic signed [DW-1:0]    delta_reg, delta_next;
    logic [XB-1:0]           x_reg, x_next;
    logic [YB-1:0]           y_reg, y_next;
    logic [CA-1:0]           caddr_reg, caddr_next;
    logic                    in_range_reg, in_range_next;
    logic                    out_valid_reg, out_valid_next;
    logic [COUNT_BITS-1:0]   out_count_reg, out_count_next;
    logic                    out_err_reg, out_err_next;

    logic                    img_we;
    logic [IA-1:0]           img_addr;
    logic [PB-1:0]           img_rdata;
    logic [PB-1:0]           pix_v;
    logic                    lvl_we;
    logic [IA-1:0]           lvl_b_addr;
    logic [LB-1:0]           lvl_a_rdata, lvl_b_rdata;
    logic                    cnt_we;
    logic [CA-1:0]           cnt_addr;
    logic [COUNT_BITS-1:0]   cnt_wdata, cnt_rdata;
    logic                    q_start, q_done;
    logic [QB-1:0]           q_level;

    logic [PIB-1:0]          total;
    logic [XB+YB-1:0]        total_full;
    logic [NWB-1:0]          nw_full;
    logic [7:0]              dir_mask;
    logic signed [1:0]       rcode, ccode;
    logic signed [CB-1:0]    dr, dc, ny, nx;
    logic signed [DW-1:0]    nidx;
    logic                    inb, last_x, last_y, advance, finish, step_bad;

    assign total_full = (XB+YB)'(w) * (XB+YB)'(h);
    assign total      = PIB'(total_full);
    assign nw_full    = NWB'(step) * NWB'(w);
    assign pix_v      = cmd.pixel[PB-1:0];
    assign dir_mask   = mode_mask(mode);
    assign rcode      = dir_row(k_reg);
    assign ccode      = dir_col(k_reg);
    assign step_bad   = !((32'(step) < 32'(w)) && (32'(step) < 32'(h)));

    always_comb
    begin
        unique case (rcode)
            2'sd1:   dr = $signed(CB'(step));
            -2'sd1:  dr = -$signed(CB'(step));
            default: dr = '0;
        endcase
        unique case (ccode)
            2'sd1:   dc = $signed(CB'(step));
            -2'sd1:  dc = -$signed(CB'(step));
            default: dc = '0;
        endcase
        ny     = $signed(CB'(y_reg)) + dr;
        nx     = $signed(CB'(x_reg)) + dc;
        inb    = (ny >= 0) && (ny < $signed(CB'(h))) && (nx >= 0) && (nx < $signed(CB'(w)));
        nidx   = $signed(DW'(idx_reg)) + delta_reg;
        last_x = (XB'(x_reg + 1'b1) == w);
        last_y = (YB'(y_reg + 1'b1) == h);
    end

    always_comb
    begin
        state_next     = state_reg;
        compute_next   = compute_reg;
        clr_next       = clr_reg;
        pix_idx_next   = pix_idx_reg;
        max_next       = max_reg;
        err_next       = err_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        nw_next        = nw_reg;
        delta_next     = delta_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        caddr_next     = caddr_reg;
        in_range_next  = in_range_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        out_err_next   = out_err_reg;
        pop            = 1'b0;
        img_we         = 1'b0;
        img_addr       = pix_idx_reg[IA-1:0];
        lvl_we         = 1'b0;
        lvl_b_addr     = nidx[IA-1:0];
        cnt_we         = 1'b0;
        cnt_addr       = clr_reg;
        cnt_wdata      = '0;
        q_start        = 1'b0;
        advance        = 1'b0;
        finish         = 1'b0;

        if (out_valid_reg && m_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    if (!compute_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        err_next = step_bad;
                        idx_next = '0;
                        if (step_bad)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            state_next = S_Q_READ;
                        end
                    end
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.kind == CMD_LOAD)
                    begin
                        pop = 1'b1;
                        if (pix_idx_reg < total)
                        begin
                            img_we       = 1'b1;
                            pix_idx_next = pix_idx_reg + 1'b1;
                            if (pix_v > max_reg)
                            begin
                                max_next = pix_v;
                            end
                        end
                        if (cmd.last)
                        begin
                            compute_next = 1'b1;
                            clr_next     = '0;
                            state_next   = S_CLEAR;
                        end
                    end
                    else if (!out_valid_reg || m_ready)
                    begin
                        pop           = 1'b1;
                        cnt_addr      = {cmd.ref_level[LB-1:0], cmd.neighbor_level[LB-1:0]};
                        in_range_next = (9'(cmd.ref_level) < 9'(MAX_LEVELS))
                                     && (9'(cmd.neighbor_level) < 9'(MAX_LEVELS));
                        state_next    = S_RD_WAIT;
                    end
                end
            end
            S_RD_WAIT:
            begin
                out_valid_next = 1'b1;
                out_count_next = in_range_reg ? cnt_rdata : '0;
                out_err_next   = err_reg;
                state_next     = S_IDLE;
            end
            S_Q_READ:
            begin
                img_addr   = idx_reg;
                state_next = S_Q_START;
            end
            S_Q_START:
            begin
                q_start    = 1'b1;
                state_next = S_Q_WAIT;
            end
            S_Q_WAIT:
            begin
                lvl_b_addr = idx_reg;
                if (q_done)
                begin
                    lvl_we = 1'b1;
                    if ((PIB'(idx_reg) + 1'b1) == total)
                    begin
                        k_next     = '0;
                        state_next = S_OFS_SEL;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_Q_READ;
                    end
                end
            end
            S_OFS_SEL:
            begin
                if (dir_mask[k_reg])
                begin
                    state_next = S_OFS_MUL;
                end
                else if (k_reg == DIR_LAST)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_OFS_MUL:
            begin
                nw_next    = (IA+1)'(nw_full);
                state_next = S_OFS_ADD;
            end
            S_OFS_ADD:
            begin
                // Linear index distance from reference to neighbor.
                unique case (rcode)
                    2'sd1:   delta_next = $signed(DW'(nw_reg));
                    -2'sd1:  delta_next = -$signed(DW'(nw_reg));
                    default: delta_next = '0;
                endcase
                delta_next = delta_next + $signed(DW'(dc));
                x_next     = '0;
                y_next     = '0;
                idx_next   = '0;
                state_next = S_PAIR;
            end
            S_PAIR:
            begin
                if (inb)
                begin
                    state_next = S_P_LVL;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            S_P_LVL:
            begin
                cnt_addr   = {lvl_a_rdata, lvl_b_rdata};
                caddr_next = {lvl_a_rdata, lvl_b_rdata};
                state_next = S_P_INC;
            end
            S_P_INC:
            begin
                cnt_we    = 1'b1;
                cnt_addr  = caddr_reg;
                cnt_wdata = (cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + 1'b1;
                advance   = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (advance)
        begin
            if (last_x && last_y)
            begin
                if (k_reg == DIR_LAST)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_OFS_SEL;
                end
            end
            else
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = S_PAIR;
                if (last_x)
                begin
                    x_next = '0;
                    y_next = y_reg + 1'b1;
                end
                else
                begin
                    x_next = x_reg + 1'b1;
                end
            end
        end

        if (finish)
        begin
            pix_idx_next = '0;
            max_next     = '0;
            compute_next = 1'b0;
            state_next   = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            compute_reg   <= 1'b0;
            clr_reg       <= '0;
            pix_idx_reg   <= '0;
            max_reg       <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            compute_reg   <= compute_next;
            clr_reg       <= clr_next;
            pix_idx_reg   <= pix_idx_next;
            max_reg       <= max_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        k_reg         <= k_next;
        nw_reg        <= nw_next;
        delta_reg     <= delta_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        caddr_reg     <= caddr_next;
        in_range_reg  <= in_range_next;
        out_count_reg <= out_count_next;
        out_err_reg   <= out_err_next;
    end

    glcm_ram #(.WIDTH(PB), .DEPTH(IDEPTH)) u_image (
        .clk   (clk),
        .we    (img_we),
        .addr  (img_addr),
        .wdata (pix_v),
        .rdata (img_rdata)
    );

    glcm_ram #(.WIDTH(LB), .DEPTH(IDEPTH)) u_level_ref (
        .clk   (clk),
        .we    (lvl_we),
        .addr  (idx_reg),
        .wdata (q_level[LB-1:0]),
        .rdata (lvl_a_rdata)
    );

    glcm_ram #(.WIDTH(LB), .DEPTH(IDEPTH)) u_level_nbr (
        .clk   (clk),
        .we    (lvl_we),
        .addr  (lvl_b_addr),
        .wdata (q_level[LB-1:0]),
        .rdata (lvl_b_rdata)
    );

    glcm_ram #(.WIDTH(COUNT_BITS), .DEPTH(CDEPTH)) u_counts (
        .clk   (clk),
        .we    (cnt_we),
        .addr  (cnt_addr),
        .wdata (cnt_wdata),
        .rdata (cnt_rdata)
    );

    glcm_quant #(.PB(PB), .QB(QB)) u_quant (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (q_start),
        .pix    (img_rdata),
        .maxv   (max_reg),
        .levels (lv),
        .done   (q_done),
        .level  (q_level)
    );

    assign m_valid         = out_valid_reg;
    assign m_count         = out_count_reg;
    assign m_err           = out_err_reg;
    assign status.clearing = (state_reg == S_CLEAR);
    assign status.rd_wait  = (state_reg == S_RD_WAIT);

endmodule

[hdl/glcm_cooccurrence_engine.sv]
// Gray-level co-occurrence matrix engine.
// Slave stream: each item is a pixel load (tuser low) or a count read (tuser
// high). Loads arrive in raster order; the load with tlast high starts the
// compute. Master stream: one item per count read, carrying the count and the
// error flag of the last compute. Config channel: writes gray levels,
// direction mode, step, width and height; writes are taken at any time
// and must only be made while the block is idle.
// Loads are absorbed at one per cycle, while the back end is idle, through
// a four-entry item queue. A read presents its count address as it leaves
// the queue; S_RD_WAIT then registers the result into the output register,
// and the next read is not taken until the state returns to S_IDLE.
// After reset, and at the start of each compute, the count memory, of
// 2^(2*ceil(log2(MAX_LEVELS))) entries, 65536 by default, is cleared one
// entry per cycle while queued items wait. A compute then quantizes each
// pixel with an iterative divider, and walks the image once per selected
// offset: a position whose neighbor falls outside takes S_PAIR alone, and a
// counted pair goes through S_PAIR, S_P_LVL and S_P_INC (a read-modify-write on the single-port count memory).
// When the receiver stalls, the result stays in the output register, further
// reads wait in the queue, and the queue backpressures the sender once full.
module glcm_cooccurrence_engine
    import glcm_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_LEVELS = 256,
    parameter int PIXEL_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [31:0]             s_tdata,   // pixel_value[15:0], ref_level[23:16], neighbor_level[31:24]
    input  logic                    s_tlast,   // last_pixel
    input  logic                    s_tuser,   // opcode
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [23:0]             m_tdata,   // pair_count[19:0], zero fill[23:20]
    output logic                    m_tuser,   // config_error
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [8:0]              cfg_data
);

    localparam int QB = $clog2(MAX_LEVELS + 1);
    localparam int XB = $clog2(MAX_WIDTH + 1);
    localparam int YB = $clog2(MAX_HEIGHT + 1);
    localparam int W_RESET = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int H_RESET = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

    // Configuration registers hold the values the datapath uses; gray levels, width and height are clamped.
    logic [QB-1:0] lv_reg;
    logic [3:0]    mode_reg;
    logic [7:0]    step_reg;
    logic [XB-1:0] w_reg;
    logic [YB-1:0] h_reg;
    logic [QB-1:0] lv_wr;
    logic [XB-1:0] w_wr;
    logic [YB-1:0] h_wr;

    cmd_t                  cmd;
    logic                  cmd_valid;
    logic                  pop;
    logic [COUNT_BITS-1:0] count;
    back_status_t          status;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (cfg_data < 9'd8)
        begin
            lv_wr = QB'(8);
        end
        else if (cfg_data > 9'(MAX_LEVELS))
        begin
            lv_wr = QB'(MAX_LEVELS);
        end
        else
        begin
            lv_wr = QB'(cfg_data);
        end

        if (cfg_data == '0)
        begin
            w_wr = XB'(1);
        end
        else if (32'(cfg_data) > 32'(MAX_WIDTH))
        begin
            w_wr = XB'(MAX_WIDTH);
        end
        else
        begin
            w_wr = XB'(cfg_data);
        end

        if (cfg_data == '0)
        begin
            h_wr = YB'(1);
        end
        else if (32'(cfg_data) > 32'(MAX_HEIGHT))
        begin
            h_wr = YB'(MAX_HEIGHT);
        end
        else
        begin
            h_wr = YB'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lv_reg   <= QB'(MAX_LEVELS);
            mode_reg <= MODE_ALL;
            step_reg <= 8'd1;
            w_reg    <= XB'(W_RESET);
            h_reg    <= YB'(H_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GRAY_LEVELS:    lv_reg   <= lv_wr;
                CFG_DIRECTION_MODE: mode_reg <= cfg_data[3:0];
                CFG_STEP_DISTANCE:  step_reg <= cfg_data[7:0];
                CFG_IMAGE_WIDTH:    w_reg    <= w_wr;
                CFG_IMAGE_HEIGHT:   h_reg    <= h_wr;
                default:
                begin
                end
            endcase
        end
    end

    glcm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .pop       (pop),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    glcm_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_LEVELS (MAX_LEVELS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .lv        (lv_reg),
        .mode      (mode_reg),
        .step      (step_reg),
        .w         (w_reg),
        .h         (h_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .pop       (pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_count   (count),
        .m_err     (m_tuser),
        .status    (status)
    );

    assign m_tdata = {4'b0000, count};

`ifndef NO_ASSERTIONS
    // The back end never takes an item from an empty queue.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cmd_valid)
        else $error("item popped from empty queue");

    // No item is executed while the count memory is being cleared.
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> !pop)
        else $error("item popped during count clear");

    // A new result appears only right after a count memory read.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(status.rd_wait))
        else $error("result without a count read");
`endif

endmodule
